### design/cfgr_pkg.sv
// Shared types, constants and state encoding for the reachability cache.
`default_nettype none
package cfgr_pkg;

  localparam int BLOCK_W          = 6;
  localparam int POS_W            = 10;
  localparam int CNT_W            = 7;
  localparam int NODES_DEFAULT    = 64;
  localparam int POSITIONS_DEFAULT = 1024;
  localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef enum logic {
    CMD_ADD_EDGE = 1'b0,
    CMD_QUERY    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               command;
    logic [BLOCK_W-1:0] from_block;
    logic [BLOCK_W-1:0] to_block;
    logic               instruction_level;
    logic [POS_W-1:0]   from_position;
    logic [POS_W-1:0]   to_position;
  } req_t;

  typedef struct packed {
    logic reachable;
    logic index_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_WB,
    ST_HIT,
    ST_SEARCH_RD,
    ST_SEARCH_WB,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

### design/cfg_reachability_cache_top.sv
// Top level of the reachability cache: request decode, memories and backward search.
`default_nettype none
// Holds a directed graph of up to MAX_NODES blocks as a predecessor matrix and answers
// whether one block reaches another. An edge add gives no response unless an index is
// out of range. A same-block query or a request with a bad index goes from decode
// straight to the result state; a query whose target column is cached first reads it
// from the reach memory. The first query for a target after any edge add runs a backward
// search that reads one predecessor row per node reached through the single read port of
// the predecessor memory. One request is in flight at a time; a finished response waits
// in an output register while the next request is taken.
module cfg_reachability_cache_top #(
  parameter int MAX_NODES     = cfgr_pkg::NODES_DEFAULT,
  parameter int MAX_POSITIONS = cfgr_pkg::POSITIONS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [cfgr_pkg::CNT_W-1:0]  cfg_data,
  input  wire logic                        req_valid,
  output      logic                        req_stall,
  input  wire cfgr_pkg::req_t              req,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  output      cfgr_pkg::rsp_t              rsp
);

  localparam int N  = MAX_NODES;
  localparam int NW = $clog2(MAX_NODES);
  localparam logic [cfgr_pkg::CNT_W-1:0] MaxCnt = cfgr_pkg::CNT_W'(MAX_NODES);
  localparam logic [16:0] PosMax = 17'(MAX_POSITIONS - 1);

  cfgr_pkg::state_t state, state_next;

  logic [cfgr_pkg::CNT_W-1:0] node_count;
  cfgr_pkg::req_t             cur;
  cfgr_pkg::rsp_t             res;

  logic [N-1:0] pred_mem [N];
  logic [N-1:0] reach_mem [N];
  logic [N-1:0] pred_ok;
  logic [N-1:0] pred_q;
  logic         pred_q_ok;
  logic [N-1:0] reach_q;
  logic [N-1:0] analyzed;
  logic [N-1:0] visited;
  logic [N-1:0] pending;

  logic [cfgr_pkg::CNT_W-1:0] cnt;
  logic          bad;
  logic          same;
  logic          pos_ok;
  logic [16:0]   fp_sat;
  logic [16:0]   tp_sat;
  logic [NW-1:0] fb;
  logic [NW-1:0] tb;
  logic [NW-1:0] pick;
  logic [N-1:0]  row;
  logic [N-1:0]  self_bit;
  logic [N-1:0]  from_bit;
  logic [N-1:0]  fresh;

  logic          req_take;
  logic          rsp_load;
  logic          pred_rd_en;
  logic [NW-1:0] pred_rd_addr;
  logic          pred_wr_en;
  logic          reach_rd_en;
  logic          reach_wr_en;

  cfgr_pick #(.N(N)) u_pick (
    .bits (pending),
    .idx  (pick)
  );

  assign cfg_ready = 1'b1;
  assign req_stall = (state != cfgr_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;

  assign cnt  = (node_count > MaxCnt) ? MaxCnt : node_count;
  assign bad  = ({1'b0, cur.from_block} >= cnt) || ({1'b0, cur.to_block} >= cnt);
  assign same = (cur.from_block == cur.to_block);
  assign fb   = cur.from_block[NW-1:0];
  assign tb   = cur.to_block[NW-1:0];

  assign fp_sat = ({7'd0, cur.from_position} > PosMax) ? PosMax : {7'd0, cur.from_position};
  assign tp_sat = ({7'd0, cur.to_position} > PosMax) ? PosMax : {7'd0, cur.to_position};
  assign pos_ok = !cur.instruction_level || (tp_sat >= fp_sat);

  assign self_bit = N'(1) << tb;
  assign from_bit = N'(1) << fb;
  assign row      = pred_q_ok ? pred_q : '0;
  assign fresh    = row & ~visited;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cfgr_pkg::ST_IDLE: begin
        if (req_take) state_next = cfgr_pkg::ST_DECODE;
      end
      cfgr_pkg::ST_DECODE: begin
        if (bad) begin
          state_next = cfgr_pkg::ST_RESULT;
        end else if (cur.command == cfgr_pkg::CMD_ADD_EDGE) begin
          state_next = cfgr_pkg::ST_EDGE_WB;
        end else if (same) begin
          state_next = cfgr_pkg::ST_RESULT;
        end else if (analyzed[tb]) begin
          state_next = cfgr_pkg::ST_HIT;
        end else begin
          state_next = cfgr_pkg::ST_SEARCH_RD;
        end
      end
      cfgr_pkg::ST_EDGE_WB:   state_next = cfgr_pkg::ST_IDLE;
      cfgr_pkg::ST_HIT:       state_next = cfgr_pkg::ST_RESULT;
      cfgr_pkg::ST_SEARCH_RD: begin
        state_next = (pending == '0) ? cfgr_pkg::ST_RESULT : cfgr_pkg::ST_SEARCH_WB;
      end
      cfgr_pkg::ST_SEARCH_WB: state_next = cfgr_pkg::ST_SEARCH_RD;
      cfgr_pkg::ST_RESULT: begin
        if (!rsp_valid || !rsp_stall) state_next = cfgr_pkg::ST_IDLE;
      end
      default: state_next = cfgr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pred_rd_en   = 1'b0;
    pred_rd_addr = tb;
    pred_wr_en   = 1'b0;
    reach_rd_en  = 1'b0;
    reach_wr_en  = 1'b0;
    rsp_load     = 1'b0;
    unique case (state)
      cfgr_pkg::ST_DECODE: begin
        if (!bad) begin
          if (cur.command == cfgr_pkg::CMD_ADD_EDGE) begin
            pred_rd_en = 1'b1;
          end else if (!same && analyzed[tb]) begin
            reach_rd_en = 1'b1;
          end
        end
      end
      cfgr_pkg::ST_EDGE_WB: pred_wr_en = 1'b1;
      cfgr_pkg::ST_SEARCH_RD: begin
        if (pending == '0) begin
          reach_wr_en = 1'b1;
        end else begin
          pred_rd_en   = 1'b1;
          pred_rd_addr = pick;
        end
      end
      cfgr_pkg::ST_RESULT: rsp_load = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (pred_wr_en) pred_mem[tb] <= row | from_bit;
    if (pred_rd_en) begin
      pred_q    <= pred_mem[pred_rd_addr];
      pred_q_ok <= pred_ok[pred_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (reach_wr_en) reach_mem[tb] <= visited & ~self_bit;
    if (reach_rd_en) reach_q <= reach_mem[tb];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cfgr_pkg::ST_IDLE;
      node_count <= cfgr_pkg::NODE_COUNT_RESET;
      pred_ok    <= '0;
      analyzed   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) node_count <= cfg_data;
      if (pred_wr_en) begin
        pred_ok[tb] <= 1'b1;
        analyzed    <= '0;
      end
      if (reach_wr_en) analyzed[tb] <= 1'b1;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req_take) cur <= req;
    if (rsp_load) rsp <= res;
    unique case (state)
      cfgr_pkg::ST_DECODE: begin
        visited <= self_bit;
        pending <= self_bit;
        if (bad) begin
          res <= '{reachable: 1'b0, index_error: 1'b1};
        end else begin
          res <= '{reachable: pos_ok, index_error: 1'b0};
        end
      end
      cfgr_pkg::ST_HIT: res <= '{reachable: reach_q[fb], index_error: 1'b0};
      cfgr_pkg::ST_SEARCH_RD: begin
        if (pending == '0) begin
          res <= '{reachable: visited[fb], index_error: 1'b0};
        end else begin
          pending[pick] <= 1'b0;
        end
      end
      cfgr_pkg::ST_SEARCH_WB: begin
        visited <= visited | fresh;
        pending <= pending | fresh;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/cfgr_pick.sv
// Lowest-set-bit encoder that picks the next pending node of the search.
`default_nettype none
module cfgr_pick #(
  parameter int N = cfgr_pkg::NODES_DEFAULT
) (
  input  wire logic [N-1:0]         bits,
  output      logic [$clog2(N)-1:0] idx
);

  localparam int NW = $clog2(N);

  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = NW'(i);
      end
    end
  end

endmodule
`default_nettype wire
